### rtl/xxh_pkg.sv
`timescale 1ns / 1ps

package xxh_pkg;

  localparam logic [31:0] PRIME1 = 32'h9E37_79B1;
  localparam logic [31:0] PRIME2 = 32'h85EB_CA77;
  localparam logic [31:0] PRIME3 = 32'hC2B2_AE3D;
  localparam logic [31:0] PRIME4 = 32'h27D4_EB2F;
  localparam logic [31:0] PRIME5 = 32'h1656_67B1;
  localparam logic [31:0] PRIME12 = PRIME1 + PRIME2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_TAKE,
    OP_LANE_W,
    OP_LANE_ROT,
    OP_LANE_P1,
    OP_FIN_INIT,
    OP_WORD_W,
    OP_BYTE_W,
    OP_H_ROT17,
    OP_H_ROT11,
    OP_H_P4,
    OP_H_P1,
    OP_XS15,
    OP_H_P2,
    OP_XS13,
    OP_H_P3,
    OP_EMIT
  } xxh_op_t;

  typedef struct packed {
    xxh_op_t    op;
    logic [3:0] idx;
  } xxh_cmd_t;

  typedef struct packed {
    logic [3:0] fill;
    logic       out_space;
  } xxh_sts_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

### rtl/xxh_ctrl.sv
`timescale 1ns / 1ps

module xxh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_byte_present,
  input  logic              in_last,
  input  xxh_pkg::xxh_sts_t sts,
  output logic              in_ready,
  output xxh_pkg::xxh_cmd_t cmd
);
  import xxh_pkg::*;

  typedef enum logic [3:0] {
    S_IN,
    S_LANE_W,
    S_LANE_ROT,
    S_LANE_P1,
    S_FIN_INIT,
    S_TAIL,
    S_TAIL_ROT,
    S_TAIL_MUL,
    S_XS15,
    S_P2,
    S_XS13,
    S_P3,
    S_EMIT
  } state_t;

  state_t     state_r;
  logic [1:0] k_r;
  logic [3:0] pos_r;
  logic       pend_last_r;
  logic       word_mode_r;
  logic [3:0] rem;
  logic       stripe_done;

  assign rem         = sts.fill - pos_r;
  assign in_ready    = (state_r == S_IN);
  assign stripe_done = in_byte_present && (sts.fill == 4'hF);

  always_comb begin
    cmd.op  = OP_NONE;
    cmd.idx = {k_r, 2'b00};
    case (state_r)
      S_IN:       cmd.op = in_valid ? OP_TAKE : OP_NONE;
      S_LANE_W:   cmd.op = OP_LANE_W;
      S_LANE_ROT: cmd.op = OP_LANE_ROT;
      S_LANE_P1:  cmd.op = OP_LANE_P1;
      S_FIN_INIT: cmd.op = OP_FIN_INIT;
      S_TAIL: begin
        cmd.idx = pos_r;
        if (rem >= 4'd4) begin
          cmd.op = OP_WORD_W;
        end else if (rem != 4'd0) begin
          cmd.op = OP_BYTE_W;
        end
      end
      S_TAIL_ROT: cmd.op = word_mode_r ? OP_H_ROT17 : OP_H_ROT11;
      S_TAIL_MUL: cmd.op = word_mode_r ? OP_H_P4 : OP_H_P1;
      S_XS15:     cmd.op = OP_XS15;
      S_P2:       cmd.op = OP_H_P2;
      S_XS13:     cmd.op = OP_XS13;
      S_P3:       cmd.op = OP_H_P3;
      S_EMIT:     cmd.op = sts.out_space ? OP_EMIT : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IN;
      k_r         <= 2'd0;
      pos_r       <= 4'd0;
      pend_last_r <= 1'b0;
      word_mode_r <= 1'b0;
    end else begin
      case (state_r)
        S_IN: begin
          if (in_valid) begin
            if (stripe_done) begin
              state_r     <= S_LANE_W;
              k_r         <= 2'd0;
              pend_last_r <= in_last;
            end else if (in_last) begin
              state_r <= S_FIN_INIT;
            end
          end
        end
        S_LANE_W:   state_r <= S_LANE_ROT;
        S_LANE_ROT: state_r <= S_LANE_P1;
        S_LANE_P1: begin
          k_r <= k_r + 2'd1;
          if (k_r == 2'd3) begin
            state_r <= pend_last_r ? S_FIN_INIT : S_IN;
          end else begin
            state_r <= S_LANE_W;
          end
        end
        S_FIN_INIT: begin
          pos_r   <= 4'd0;
          state_r <= S_TAIL;
        end
        S_TAIL: begin
          if (rem >= 4'd4) begin
            word_mode_r <= 1'b1;
            state_r     <= S_TAIL_ROT;
          end else if (rem != 4'd0) begin
            word_mode_r <= 1'b0;
            state_r     <= S_TAIL_ROT;
          end else begin
            state_r <= S_XS15;
          end
        end
        S_TAIL_ROT: state_r <= S_TAIL_MUL;
        S_TAIL_MUL: begin
          pos_r   <= pos_r + (word_mode_r ? 4'd4 : 4'd1);
          state_r <= S_TAIL;
        end
        S_XS15: state_r <= S_P2;
        S_P2:   state_r <= S_XS13;
        S_XS13: state_r <= S_P3;
        S_P3:   state_r <= S_EMIT;
        S_EMIT: begin
          if (sts.out_space) begin
            state_r <= S_IN;
          end
        end
        default: state_r <= S_IN;
      endcase
    end
  end

  a_tail_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TAIL |-> pos_r <= sts.fill)
    else $error("tail position beyond fill");

  a_stripe_fold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && stripe_done |=> state_r == S_LANE_W && k_r == 2'd0)
    else $error("full stripe not folded");

  a_word_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TAIL_MUL && word_mode_r |=> pos_r[1:0] == 2'b00)
    else $error("word fold misaligned");

endmodule

### rtl/xxh_dp.sv
`timescale 1ns / 1ps

module xxh_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  xxh_pkg::xxh_cmd_t cmd,
  input  logic [7:0]        in_data_byte,
  input  logic              in_byte_present,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_hash_seed,
  input  logic              out_ready,
  output xxh_pkg::xxh_sts_t sts,
  output logic              out_valid,
  output logic [31:0]       out_digest
);
  import xxh_pkg::*;

  logic [31:0] seed_r;
  logic [31:0] lane_r [4];
  logic [7:0]  buf_r [4][4];
  logic [3:0]  fill_r;
  logic [31:0] len_r;
  logic        seen_r;
  logic [31:0] h_r;
  logic [31:0] prod_r;
  logic        out_valid_r;
  logic [31:0] out_digest_r;

  logic [1:0]  wi;
  logic [31:0] word;
  logic [7:0]  byte_sel;
  logic [31:0] lane_sel;
  logic [31:0] merge;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_p;
  logic        start;
  logic        take;

  assign wi       = cmd.idx[3:2];
  assign word     = {buf_r[wi][3], buf_r[wi][2], buf_r[wi][1], buf_r[wi][0]};
  assign byte_sel = buf_r[wi][cmd.idx[1:0]];
  assign lane_sel = lane_r[wi];
  assign merge    = rotl32(lane_r[0], 1) + rotl32(lane_r[1], 7)
                  + rotl32(lane_r[2], 12) + rotl32(lane_r[3], 18);
  assign start    = (len_r == 32'd0) && !seen_r;
  assign take     = (cmd.op == OP_TAKE) && in_byte_present;

  always_comb begin
    mul_a = h_r;
    mul_b = PRIME1;
    case (cmd.op)
      OP_LANE_W:  begin mul_a = word;            mul_b = PRIME2; end
      OP_LANE_P1: begin mul_a = lane_sel;        mul_b = PRIME1; end
      OP_WORD_W:  begin mul_a = word;            mul_b = PRIME3; end
      OP_BYTE_W:  begin mul_a = {24'd0, byte_sel}; mul_b = PRIME5; end
      OP_H_P4:    mul_b = PRIME4;
      OP_H_P2:    mul_b = PRIME2;
      OP_H_P3:    mul_b = PRIME3;
      default:    mul_b = PRIME1;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign sts.fill      = fill_r;
  assign sts.out_space = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_digest    = out_digest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= 32'd0;
      fill_r      <= 4'd0;
      len_r       <= 32'd0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_hash_seed;
      end
      if (take) begin
        fill_r <= fill_r + 4'd1;
        len_r  <= len_r + 32'd1;
        if (fill_r == 4'hF) begin
          seen_r <= 1'b1;
        end
      end
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
        fill_r      <= 4'd0;
        len_r       <= 32'd0;
        seen_r      <= 1'b0;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_TAKE: begin
        if (in_byte_present) begin
          if (start) begin
            lane_r[0] <= seed_r + PRIME12;
            lane_r[1] <= seed_r + PRIME2;
            lane_r[2] <= seed_r;
            lane_r[3] <= seed_r - PRIME1;
          end
          buf_r[fill_r[3:2]][fill_r[1:0]] <= in_data_byte;
        end
      end
      OP_LANE_W, OP_WORD_W, OP_BYTE_W: prod_r <= mul_p;
      OP_LANE_ROT: lane_r[wi] <= rotl32(lane_sel + prod_r, 13);
      OP_LANE_P1:  lane_r[wi] <= mul_p;
      OP_FIN_INIT: h_r <= (seen_r ? merge : seed_r + PRIME5) + len_r;
      OP_H_ROT17:  h_r <= rotl32(h_r + prod_r, 17);
      OP_H_ROT11:  h_r <= rotl32(h_r + prod_r, 11);
      OP_H_P4, OP_H_P1, OP_H_P2, OP_H_P3: h_r <= mul_p;
      OP_XS15:     h_r <= h_r ^ (h_r >> 15);
      OP_XS13:     h_r <= h_r ^ (h_r >> 13);
      OP_EMIT:     out_digest_r <= h_r ^ (h_r >> 16);
      default: ;
    endcase
  end

  a_stripe_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    take && fill_r == 4'hF |=> fill_r == 4'd0 && seen_r)
    else $error("stripe fill did not wrap");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_EMIT |=> out_valid_r && len_r == 32'd0 && !seen_r)
    else $error("digest transfer did not reset message state");

  a_short_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FIN_INIT && !seen_r |=> h_r == $past(seed_r + PRIME5 + len_r))
    else $error("short message start value wrong");

endmodule

### rtl/xxh32_stream_hasher_core.sv
// A byte that does not complete a 16-byte stripe and is not the last leaves the core ready for more.
// A byte that completes a stripe folds the four lanes in turn on the shared multiplier.
// After a last item, the lanes are folded first if that item completed a stripe, then tail
// words and then tail bytes are folded and out_valid rises; the tail fold shares that multiplier.
// Synchronous active-low reset clears control state and the seed; the seed register
// is written at any cfg transfer and lanes load from it at the first byte of a message.
`timescale 1ns / 1ps

module xxh32_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_hash_seed
);
  import xxh_pkg::*;

  xxh_cmd_t cmd;
  xxh_sts_t sts;

  assign cfg_ready = 1'b1;

  xxh_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_byte_present (in_byte_present),
    .in_last         (in_last),
    .sts             (sts),
    .in_ready        (in_ready),
    .cmd             (cmd)
  );

  xxh_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_hash_seed   (cfg_hash_seed),
    .out_ready       (out_ready),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_digest      (out_digest)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [31:0] XP1 = 32'h9E37_79B1;
  localparam logic [31:0] XP2 = 32'h85EB_CA77;
  localparam logic [31:0] XP3 = 32'hC2B2_AE3D;
  localparam logic [31:0] XP4 = 32'h27D4_EB2F;
  localparam logic [31:0] XP5 = 32'h1656_67B1;

  localparam int IDLE_PAUSE  = 60;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int RAND_ITEMS  = 1050;
  localparam int MIN_MSGS    = 40;
  localparam int DIR_ROWS    = 24;

  typedef struct packed {
    logic [7:0]  data;
    logic        present;
    logic        last;
    logic        typed;
    logic [31:0] digest;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } byte_item_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_mode_t;

  // data, present, last, typed, digest
  localparam logic [0:DIR_ROWS-1][42:0] DIRECTED = {
    {8'hA5, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    {8'hFF, 1'b0, 1'b1, 1'b1, 32'h02CC_5D05},
    {8'h00, 1'b1, 1'b1, 1'b0, 32'h0000_0000},
    {8'hFF, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'h00, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'h80, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'h7F, 1'b1, 1'b1, 1'b0, 32'h0000_0000},
    {8'h01, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'h02, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'h04, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'h08, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'h10, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'h20, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'h40, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'h80, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'hFE, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'hFD, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'hFB, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'hF7, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'hEF, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'hDF, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'hBF, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'h7F, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    {8'h3C, 1'b0, 1'b1, 1'b0, 32'h0000_0000}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_hash_seed = 32'h0;

  // digest predictor state
  logic [31:0] seed_reg = 32'h0;
  logic [31:0] lanes [4];
  logic [7:0]  stripe [16];
  int unsigned fill_cnt = 0;
  logic [31:0] msg_len = 32'h0;
  bit          stripe_done = 1'b0;

  logic [31:0] expected_digests [$];
  bit          typed_en = 1'b0;
  logic [31:0] typed_val = 32'h0;

  int errors = 0;
  int digests_checked = 0;
  int items_counted = 0;
  int messages_done = 0;
  int seed_writes = 0;
  int burst_left = 0;
  int unsigned cycles = 0;
  int unsigned ready_tick = 0;
  rx_mode_t    ready_mode = RX_OPEN;

  xxh32_stream_hasher_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest      (out_digest),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_hash_seed   (cfg_hash_seed)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int unsigned r);
    logic [63:0] both;
    both = {x, x} << r;
    return both[63:32];
  endfunction

  function automatic logic [31:0] stripe_word(input int unsigned pos);
    return {stripe[(pos + 3) % 16], stripe[(pos + 2) % 16],
            stripe[(pos + 1) % 16], stripe[pos % 16]};
  endfunction

  function automatic logic [31:0] fold_lane(input logic [31:0] acc, input logic [31:0] w);
    logic [31:0] a;
    a = acc + w * XP2;
    a = rot_left(a, 13);
    return a * XP1;
  endfunction

  function automatic logic [31:0] message_digest();
    logic [31:0] h;
    int unsigned pos;
    pos = 0;
    if (stripe_done) begin
      h = rot_left(lanes[0], 1) + rot_left(lanes[1], 7)
        + rot_left(lanes[2], 12) + rot_left(lanes[3], 18);
    end else begin
      h = seed_reg + XP5;
    end
    h = h + msg_len;
    while (pos + 4 <= fill_cnt) begin
      h = h + stripe_word(pos) * XP3;
      h = rot_left(h, 17) * XP4;
      pos += 4;
    end
    while (pos < fill_cnt) begin
      h = h + {24'h0, stripe[pos]} * XP5;
      h = rot_left(h, 11) * XP1;
      pos++;
    end
    h = h ^ (h >> 15);
    h = h * XP2;
    h = h ^ (h >> 13);
    h = h * XP3;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // advances the predictor by one input transfer; returns 1 when a digest is due
  function automatic bit absorb_item(input logic [7:0] data, input logic present,
                                     input logic last, output logic [31:0] digest);
    digest = 32'h0;
    if (present) begin
      if (msg_len == 0 && !stripe_done) begin
        lanes[0] = seed_reg + XP1 + XP2;
        lanes[1] = seed_reg + XP2;
        lanes[2] = seed_reg;
        lanes[3] = seed_reg - XP1;
      end
      stripe[fill_cnt] = data;
      fill_cnt++;
      msg_len = msg_len + 1;
      if (fill_cnt == 16) begin
        for (int k = 0; k < 4; k++) lanes[k] = fold_lane(lanes[k], stripe_word(4 * k));
        fill_cnt = 0;
        stripe_done = 1'b1;
      end
    end
    if (!last) return 1'b0;
    digest = message_digest();
    fill_cnt = 0;
    msg_len = 32'h0;
    stripe_done = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : observe
    logic [31:0] fresh;
    logic [31:0] want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) seed_reg = cfg_hash_seed;
      if (in_valid && in_ready) begin
        if (absorb_item(in_data_byte, in_byte_present, in_last, fresh)) begin
          expected_digests.push_back(typed_en ? typed_val : fresh);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_digests.size() == 0) begin
          errors++;
          if (errors < 40) begin
            $display("%0t: digest transfer, expected none, got %h", $time, out_digest);
          end
        end else begin
          want = expected_digests.pop_front();
          digests_checked++;
          if (out_digest !== want) begin
            errors++;
            if (errors < 40) begin
              $display("%0t: digest mismatch, expected %h, got %h", $time, want, out_digest);
            end
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    ready_tick++;
    if (ready_tick % 97 == 0) ready_mode = rx_mode_t'($urandom_range(0, 3));
    case (ready_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (ready_tick % 5 == 0);
      default: out_ready <= (ready_tick % 11 >= 8);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] data, input logic present, input logic last,
                           input bit hold);
    int gap;
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_byte_present <= present;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (present || last) items_counted++;
    if (hold) begin
      in_valid <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    end
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_hash_seed <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    seed_writes++;
  endtask

  // let outstanding digests drain and the core settle
  task automatic wait_idle();
    while (expected_digests.size() != 0) @(negedge clk);
    repeat (IDLE_PAUSE) @(negedge clk);
  endtask

  initial begin
    dir_row_t    row;
    byte_item_t  msg_q [$];
    byte_item_t  it;
    int          len;
    int          split;
    int          r;
    int          n_msgs;
    int          phase;
    int          rand_base;
    bit          tail_absent;
    bit          hold;
    logic [31:0] seed_pick;

    for (int i = 0; i < 4; i++) lanes[i] = 32'h0;
    for (int i = 0; i < 16; i++) stripe[i] = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_seed(32'h0);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_row_t'(DIRECTED[i]);
      typed_en = row.typed;
      typed_val = row.digest;
      send_item(row.data, row.present, row.last, i == DIR_ROWS - 1);
    end
    typed_en = 1'b0;

    rand_base = items_counted;
    phase = 0;
    while (items_counted - rand_base < RAND_ITEMS || messages_done < MIN_MSGS) begin
      wait_idle();
      case (phase)
        0: seed_pick = 32'hFFFF_FFFF;
        1: seed_pick = 32'h0000_0000;
        2: seed_pick = 32'h8000_0000;
        3: seed_pick = 32'h0000_0001;
        default: seed_pick = $urandom;
      endcase
      write_seed(seed_pick);
      n_msgs = $urandom_range(3, 8);
      for (int m = 0; m < n_msgs; m++) begin
        r = $urandom_range(0, 99);
        if (r < 10) len = 0;
        else if (r < 50) len = $urandom_range(1, 15);
        else if (r < 60) len = 16 * $urandom_range(1, 3);
        else if (r < 85) len = $urandom_range(17, 40);
        else len = $urandom_range(41, 80);
        tail_absent = (len == 0) || ($urandom_range(0, 9) < 3);
        msg_q.delete();
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 9) == 0) begin
            it.data = 8'($urandom_range(0, 255));
            it.present = 1'b0;
            it.last = 1'b0;
            msg_q.push_back(it);
          end
          it.data = 8'($urandom_range(0, 255));
          it.present = 1'b1;
          it.last = !tail_absent && (j == len - 1);
          msg_q.push_back(it);
        end
        if (tail_absent) begin
          it.data = 8'($urandom_range(0, 255));
          it.present = 1'b0;
          it.last = 1'b1;
          msg_q.push_back(it);
        end
        // occasional seed change in the middle of a message
        split = (msg_q.size() >= 2 && $urandom_range(0, 11) == 0) ?
                $urandom_range(0, msg_q.size() - 2) : -1;
        for (int k = 0; k < msg_q.size(); k++) begin
          hold = (k == split) || (m == n_msgs - 1 && k == msg_q.size() - 1);
          send_item(msg_q[k].data, msg_q[k].present, msg_q[k].last, hold);
          if (k == split) begin
            wait_idle();
            write_seed($urandom);
          end
        end
        messages_done++;
      end
      phase++;
    end

    wait_idle();
    $display("Hashed %0d messages from %0d byte and end transfers under %0d seed writes",
             messages_done, items_counted, seed_writes);
    $display("%0d digests compared, %0d failing transfers", digests_checked, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
rtl/xxh_pkg.sv
rtl/xxh_ctrl.sv
rtl/xxh_dp.sv
rtl/xxh32_stream_hasher_core.sv
tb/tb.sv
